FILE: hdl/lplr_pkg.sv
// ----------------------------------------------------------------------------
// lplr_pkg : shared types and constants for the line preserving log ring
// Ring size, index type, opcodes and memory request structs.
// ----------------------------------------------------------------------------
package lplr_pkg;

   localparam int RING_OCTETS = 1024;
   localparam int IDX_W       = $clog2(RING_OCTETS);
   localparam int LEN_W       = (IDX_W > 12) ? IDX_W : 12;
   localparam int USED_W      = 10;

   localparam logic [1:0] OP_RESERVE = 2'd0;
   localparam logic [1:0] OP_APPEND  = 2'd1;
   localparam logic [1:0] OP_READ    = 2'd2;
   localparam logic [1:0] OP_ACK     = 2'd3;

   localparam logic [7:0] NEWLINE_OCTET = 8'h0A;

   typedef logic [IDX_W-1:0] idx_type;

   typedef struct packed {
      logic       en;
      idx_type    addr;
      logic [7:0] data;
   } wr_req_type;

   typedef struct packed {
      logic    en;
      idx_type addr;
   } rd_req_type;

   // wrap-around increment, ring size need not be a power of two
   function automatic idx_type idx_next(idx_type i);
      idx_type r;
      if (i == IDX_W'(RING_OCTETS - 1)) begin
         r = '0;
      end else begin
         r = i + 1'b1;
      end
      return r;
   endfunction

endpackage

FILE: hdl/lplr_ring_ram.sv
// ----------------------------------------------------------------------------
// lplr_ring_ram : octet storage of the log ring
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lplr_ring_ram
   import lplr_pkg::*;
(
   input  logic       clock,
   input  wr_req_type wr_req,
   input  rd_req_type rd_req,
   output logic [7:0] rd_data
);

   logic [7:0] mem [RING_OCTETS];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_req.en) begin
         mem[wr_req.addr] <= wr_req.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_req.en) begin
         rd_data_ff <= mem[rd_req.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/line_preserving_log_ring.sv
// ----------------------------------------------------------------------------
// line_preserving_log_ring : octet log ring that drops whole old lines
// Append, read and acknowledge beats need no walk; reserve walks the
// tail one dropped octet per cycle until the new line fits at a line start.
// ----------------------------------------------------------------------------
// Response: append, read, acknowledge and zero-length reserve register
//   their response strobe at the accepting edge.
// Reserve with length > 0: busy stays high while tail octets are dropped and
//   through a final check, then the response strobes; the walk is set by the
//   one read port of the ring memory (one tail octet examined per cycle).
// Throughput: one beat per cycle for everything but a nonzero reserve.
// Reset (synchronous, active high) clears indices, reservation, drop count
//   and loss flag; the ring memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module line_preserving_log_ring
   import lplr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // command channel
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_opcode,
   input  logic [7:0]        req_octet,
   input  logic [11:0]       req_line_length,
   // response channel, one strobed cycle per beat
   output logic              rsp_strobe,
   output logic [7:0]        rsp_read_octet,
   output logic              rsp_read_valid,
   output logic              rsp_append_taken,
   output logic [USED_W-1:0] rsp_used_octets,
   output logic [31:0]       rsp_dropped_total,
   output logic              rsp_drop_pending
);

   typedef enum logic {
      ST_IDLE,
      ST_DROP
   } state_type;

   state_type   state_ff;
   idx_type     head_ff;
   idx_type     tail_ff;
   idx_type     reserve_left_ff;
   idx_type     need_ff;      // clamped length of the pending reserve
   logic        first_ff;     // walk starts as if at a line start
   logic [31:0] drop_count_ff;
   logic        loss_ff;
   logic        rsp_strobe_ff;
   logic        rsp_read_valid_ff;
   logic        rsp_append_taken_ff;

   wr_req_type  wr_req;
   rd_req_type  rd_req;
   logic [7:0]  rd_data;

   logic        accept;
   logic        nonempty;
   logic [IDX_W:0] diff;
   idx_type     used;
   idx_type     free_slots;
   logic [LEN_W-1:0] len_ext;
   idx_type     len_clamped;
   logic        at_start;
   logic        drop_go;
   logic        append_ok;

   assign accept   = start && (state_ff == ST_IDLE);
   assign busy     = (state_ff != ST_IDLE);
   assign nonempty = (head_ff != tail_ff);

   // occupancy, modulo a ring size that may not be a power of two
   assign diff = {1'b0, head_ff} - {1'b0, tail_ff};
   always_comb begin
      if (head_ff >= tail_ff) begin
         used = IDX_W'(diff);
      end else begin
         used = IDX_W'(diff + (IDX_W + 1)'(RING_OCTETS));
      end
   end
   assign free_slots = IDX_W'(RING_OCTETS - 1) - used;

   // overlong lines are cut to what the ring can hold
   assign len_ext = LEN_W'(req_line_length);
   assign len_clamped = (len_ext > LEN_W'(RING_OCTETS - 1)) ? IDX_W'(RING_OCTETS - 1)
                                                            : IDX_W'(len_ext);

   // read data holds the octet dropped in the previous walk cycle
   assign at_start = first_ff || (rd_data == NEWLINE_OCTET);
   assign drop_go  = (state_ff == ST_DROP) && nonempty &&
                     ((free_slots < need_ff) || !at_start);

   assign append_ok = (reserve_left_ff != '0) && (free_slots != '0);

   // memory ports: the write only on append, reads on pop and on drop walk
   always_comb begin
      wr_req.en   = accept && (req_opcode == OP_APPEND) && append_ok;
      wr_req.addr = head_ff;
      wr_req.data = req_octet;
      rd_req.en   = (accept && (req_opcode == OP_READ) && nonempty) || drop_go;
      rd_req.addr = tail_ff;
   end

   lplr_ring_ram u_ram (
      .clock   (clock),
      .wr_req  (wr_req),
      .rd_req  (rd_req),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff            <= ST_IDLE;
         head_ff             <= '0;
         tail_ff             <= '0;
         reserve_left_ff     <= '0;
         need_ff             <= '0;
         first_ff            <= 1'b1;
         drop_count_ff       <= '0;
         loss_ff             <= 1'b0;
         rsp_strobe_ff       <= 1'b0;
         rsp_read_valid_ff   <= 1'b0;
         rsp_append_taken_ff <= 1'b0;
      end else begin
         rsp_strobe_ff       <= 1'b0;
         rsp_read_valid_ff   <= 1'b0;
         rsp_append_taken_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  unique case (req_opcode)
                     OP_RESERVE: begin
                        if (len_clamped == '0) begin
                           reserve_left_ff <= '0;
                           rsp_strobe_ff   <= 1'b1;
                        end else begin
                           need_ff  <= len_clamped;
                           first_ff <= 1'b1;
                           state_ff <= ST_DROP;
                        end
                     end
                     OP_APPEND: begin
                        if (append_ok) begin
                           head_ff             <= idx_next(head_ff);
                           reserve_left_ff     <= reserve_left_ff - 1'b1;
                           rsp_append_taken_ff <= 1'b1;
                        end
                        rsp_strobe_ff <= 1'b1;
                     end
                     OP_READ: begin
                        if (nonempty) begin
                           tail_ff           <= idx_next(tail_ff);
                           rsp_read_valid_ff <= 1'b1;
                        end
                        rsp_strobe_ff <= 1'b1;
                     end
                     OP_ACK: begin
                        loss_ff       <= 1'b0;
                        rsp_strobe_ff <= 1'b1;
                     end
                     default: begin
                        rsp_strobe_ff <= 1'b1;
                     end
                  endcase
               end
            end
            ST_DROP: begin
               if (drop_go) begin
                  tail_ff       <= idx_next(tail_ff);
                  drop_count_ff <= drop_count_ff + 32'd1;
                  loss_ff       <= 1'b1;
                  first_ff      <= 1'b0;
               end else begin
                  reserve_left_ff <= need_ff;
                  rsp_strobe_ff   <= 1'b1;
                  state_ff        <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // read data register is stable through the strobe cycle
   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_read_valid    = rsp_read_valid_ff;
   assign rsp_read_octet    = rsp_read_valid_ff ? rd_data : 8'd0;
   assign rsp_append_taken  = rsp_append_taken_ff;
   assign rsp_used_octets   = USED_W'(used);
   assign rsp_dropped_total = drop_count_ff;
   assign rsp_drop_pending  = loss_ff;

   // the walk never overlaps a write to the ring
   a_no_write_in_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DROP) |-> !wr_req.en)
      else $error("ring write during drop walk");

   // once an octet has been dropped in this walk, the loss flag is up
   a_loss_after_drop: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DROP && !first_ff) |-> loss_ff)
      else $error("dropped octet without loss flag");

   // responses only leave after the walk is over
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> (state_ff == ST_IDLE))
      else $error("response strobe while walking");

   // append, read and acknowledge answer on the next cycle
   a_quick_rsp: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_opcode == OP_APPEND || req_opcode == OP_READ ||
                  req_opcode == OP_ACK)) |=> rsp_strobe_ff)
      else $error("missing response for single-cycle command");

   // a taken append and a valid read cannot share one response
   a_excl_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> !(rsp_read_valid_ff && rsp_append_taken_ff))
      else $error("read and append flags both set");

endmodule
